// ----- sv/wfr_pkg.sv -----
package wfr_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned M_TDATA_W = 80;

	localparam logic [6:0] LEN_SINGLE_MAX = 7'd125;
	localparam logic [6:0] LEN_EXT16      = 7'd126;
	localparam logic [6:0] LEN_EXT64      = 7'd127;
	localparam logic [7:0] OPCODE_BITS    = 8'h0f;

	localparam logic [3:0] OPC_BINARY = 4'd2;
	localparam logic [3:0] OPC_CLOSE  = 4'd8;
	localparam logic [3:0] OPC_PONG   = 4'd10;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [1:0] ERR_NO_MASK = 2'd0;
	localparam logic [1:0] ERR_RSV     = 2'd1;
	localparam logic [1:0] ERR_CONTROL = 2'd2;
	localparam logic [1:0] ERR_OPCODE  = 2'd3;

	typedef enum logic [2:0] {
		PH_HDR1     = 3'd0,
		PH_HDR2     = 3'd1,
		PH_HDR2_RSV = 3'd2,
		PH_EXTLEN   = 3'd3,
		PH_MASK     = 3'd4,
		PH_PAYLOAD  = 3'd5,
		PH_ERROR    = 3'd6
	} phase_t;

	// one classified transaction waiting for the back end
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  opcode;
		logic        fin;
		logic [63:0] len;
		logic [7:0]  raw;
		logic [7:0]  key;
		logic        last;
		logic [1:0]  err;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

// ----- sv/wfr_front.sv -----
module wfr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          q_ready,
	output wfr_pkg::push_t push
);
	import wfr_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        fin_q, fin_n;
	logic [3:0]  len_left_q, len_left_n;
	logic [63:0] len_accum_q, len_accum_n;
	logic [31:0] mask_key_q, mask_key_n;
	logic [2:0]  mask_left_q, mask_left_n;
	logic [63:0] payload_left_q, payload_left_n;
	logic [1:0]  mask_pos_q, mask_pos_n;

	logic        accept;
	logic [7:0]  b;
	logic [6:0]  code;
	logic        hdr_ok;
	logic [1:0]  hdr_err;
	logic [3:0]  len_dec;
	logic [2:0]  mask_dec;
	logic [63:0] pay_dec;
	logic [31:0] key_shift;

	assign s_tready = q_ready;
	assign accept   = s_tvalid && s_tready;
	assign b        = s_tdata;
	assign code     = b[6:0];
	assign len_dec  = len_left_q - 4'd1;
	assign mask_dec = mask_left_q - 3'd1;
	assign pay_dec  = payload_left_q - 64'd1;
	assign key_shift = {mask_key_q[23:0], b};

	// header checks in priority order
	always_comb begin
		hdr_ok  = 1'b1;
		hdr_err = ERR_NO_MASK;
		if (!b[7]) begin
			hdr_ok  = 1'b0;
			hdr_err = ERR_NO_MASK;
		end else if (phase_q == PH_HDR2_RSV) begin
			hdr_ok  = 1'b0;
			hdr_err = ERR_RSV;
		end else if (opcode_q <= OPC_BINARY) begin
			hdr_ok = 1'b1;
		end else if (opcode_q >= OPC_CLOSE && opcode_q <= OPC_PONG) begin
			if (code > LEN_SINGLE_MAX || !fin_q) begin
				hdr_ok  = 1'b0;
				hdr_err = ERR_CONTROL;
			end
		end else begin
			hdr_ok  = 1'b0;
			hdr_err = ERR_OPCODE;
		end
	end

	always_comb begin
		phase_n        = phase_q;
		opcode_n       = opcode_q;
		fin_n          = fin_q;
		len_left_n     = len_left_q;
		len_accum_n    = len_accum_q;
		mask_key_n     = mask_key_q;
		mask_left_n    = mask_left_q;
		payload_left_n = payload_left_q;
		mask_pos_n     = mask_pos_q;
		push.valid        = 1'b0;
		push.entry.kind   = KIND_HEADER;
		push.entry.opcode = opcode_q;
		push.entry.fin    = fin_q;
		push.entry.len    = '0;
		push.entry.raw    = '0;
		push.entry.key    = '0;
		push.entry.last   = 1'b0;
		push.entry.err    = ERR_NO_MASK;
		if (accept) begin
			unique case (phase_q)
				PH_HDR1: begin
					fin_n    = b[7];
					opcode_n = 4'(b & OPCODE_BITS);
					phase_n  = (|b[6:4]) ? PH_HDR2_RSV : PH_HDR2;
				end
				PH_HDR2, PH_HDR2_RSV: begin
					if (!hdr_ok) begin
						phase_n         = PH_ERROR;
						push.valid      = 1'b1;
						push.entry.kind = KIND_ERROR;
						push.entry.err  = hdr_err;
					end else if (code == LEN_EXT16) begin
						len_accum_n = '0;
						len_left_n  = 4'd2;
						phase_n     = PH_EXTLEN;
					end else if (code == LEN_EXT64) begin
						len_accum_n = '0;
						len_left_n  = 4'd8;
						phase_n     = PH_EXTLEN;
					end else begin
						len_accum_n = {57'd0, code};
						len_left_n  = 4'd0;
						mask_left_n = 3'd4;
						mask_key_n  = '0;
						phase_n     = PH_MASK;
					end
				end
				PH_EXTLEN: begin
					len_accum_n = {len_accum_q[55:0], b};
					len_left_n  = len_dec;
					if (len_dec == 4'd0) begin
						mask_left_n = 3'd4;
						mask_key_n  = '0;
						phase_n     = PH_MASK;
					end
				end
				PH_MASK: begin
					mask_key_n  = key_shift;
					mask_left_n = mask_dec;
					if (mask_dec == 3'd0) begin
						payload_left_n  = len_accum_q;
						mask_pos_n      = 2'd0;
						push.valid      = 1'b1;
						push.entry.kind = KIND_HEADER;
						push.entry.len  = len_accum_q;
						push.entry.last = (len_accum_q == 64'd0);
						phase_n = (len_accum_q == 64'd0) ? PH_HDR1 : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					mask_pos_n      = mask_pos_q + 2'd1;
					payload_left_n  = pay_dec;
					push.valid      = 1'b1;
					push.entry.kind = KIND_PAYLOAD;
					push.entry.raw  = b;
					// first mask byte received sits in the top bits
					case (mask_pos_q)
						2'd0:    push.entry.key = mask_key_q[31:24];
						2'd1:    push.entry.key = mask_key_q[23:16];
						2'd2:    push.entry.key = mask_key_q[15:8];
						default: push.entry.key = mask_key_q[7:0];
					endcase
					push.entry.last = (pay_dec == 64'd0);
					if (pay_dec == 64'd0) begin
						phase_n = PH_HDR1;
					end
				end
				default: begin
					phase_n = PH_ERROR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR1;
			opcode_q       <= '0;
			fin_q          <= 1'b0;
			len_left_q     <= '0;
			len_accum_q    <= '0;
			mask_key_q     <= '0;
			mask_left_q    <= '0;
			payload_left_q <= '0;
			mask_pos_q     <= '0;
		end else begin
			phase_q        <= phase_n;
			opcode_q       <= opcode_n;
			fin_q          <= fin_n;
			len_left_q     <= len_left_n;
			len_accum_q    <= len_accum_n;
			mask_key_q     <= mask_key_n;
			mask_left_q    <= mask_left_n;
			payload_left_q <= payload_left_n;
			mask_pos_q     <= mask_pos_n;
		end
	end

endmodule

// ----- sv/wfr_queue.sv -----
module wfr_queue #(
	parameter int unsigned DEPTH = wfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wfr_pkg::push_t push,
	output logic           in_ready,
	output logic           out_valid,
	output wfr_pkg::entry_t out_entry,
	input  logic           pop
);
	import wfr_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign in_ready  = (count_q != FULL_CNT);
	assign out_valid = (count_q != '0);
	assign out_entry = slots_q[rd_ptr_q];
	assign do_push   = push.valid && in_ready;
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- sv/wfr_back.sv -----
module wfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  wfr_pkg::entry_t q_entry,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [wfr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);
	import wfr_pkg::*;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  opcode_q;
	logic        fin_q;
	logic [63:0] len_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [1:0]  err_q;

	// output register refills whenever it is empty or being drained
	assign pop = q_valid && (!valid_q || m_tready);

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= q_entry.kind;
			opcode_q <= q_entry.opcode;
			fin_q    <= q_entry.fin;
			len_q    <= q_entry.len;
			data_q   <= q_entry.raw ^ q_entry.key;
			last_q   <= q_entry.last;
			err_q    <= q_entry.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {1'b0, err_q, data_q, len_q, fin_q, opcode_q};

endmodule

// ----- sv/websocket_frame_receiver_unit.sv -----
// Client-to-server websocket frame receiver. Takes one stream byte per cycle on the s_ side
// while s_tready is high, parses the frame header, extended length and masking key, and
// returns one header transaction, then every unmasked payload byte with tlast on the final
// one (or on the header of an empty frame). A malformed header gives one error transaction,
// after which all input is dropped until arst_n. Each byte needs only a small parser state
// update, so input and output each run at one transaction per clock while neither side
// stalls; a result enters the queue on the edge that takes its byte, then moves on to the
// output register. Between the parser and the output register sits a queue of QUEUE_DEPTH
// entries, so s_tready only falls once the queue is full while the sink stalls.
module websocket_frame_receiver_unit #(
	parameter int unsigned QUEUE_DEPTH = wfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // rx_byte[7:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	// opcode[3:0], final_fragment[4], payload_len[68:5], data_byte[76:69],
	// error_code[78:77], zero fill[79]
	output logic [wfr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [1:0] m_tuser,   // kind[1:0]
	output logic       m_tlast
);
	import wfr_pkg::*;

	push_t  push;
	logic   q_ready;
	logic   q_valid;
	entry_t q_entry;
	logic   pop;

	wfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_ready  (q_ready),
		.push     (push)
	);

	wfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_ready  (q_ready),
		.out_valid (q_valid),
		.out_entry (q_entry),
		.pop       (pop)
	);

	wfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
	import wfr_pkg::*;

	localparam logic [3:0] OPC_CONT = 4'd0;
	localparam logic [3:0] OPC_TEXT = 4'd1;
	localparam logic [3:0] OPC_PING = 4'd9;
	localparam int unsigned RANDOM_BYTES = 1550;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  opc;
		logic        fin;
		logic [63:0] len;
		logic [7:0]  data;
		logic        last;
		logic [1:0]  err;
	} rx_result_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		rx_result_t res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	websocket_frame_receiver_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// parser state mirrored by the predictor
	phase_t      ph = PH_HDR1;
	logic [3:0]  cur_opc = '0;
	logic        cur_fin = 1'b0;
	logic [3:0]  len_bytes_left = '0;
	logic [63:0] len_accum = '0;
	logic [31:0] mask_key = '0;
	logic [2:0]  mask_bytes_left = '0;
	logic [63:0] payload_left = '0;
	logic [1:0]  mask_pos = '0;

	rx_result_t  pending_results[$];
	stim_row_t   stim_table[$];
	int          fails = 0;
	int unsigned bytes_sent = 0;
	bit          quiet = 1'b0;

	function automatic rx_result_t hdr_res(logic [3:0] opc, logic fin, logic [63:0] len,
			logic last);
		rx_result_t r;
		r = '0;
		r.kind = KIND_HEADER;
		r.opc = opc;
		r.fin = fin;
		r.len = len;
		r.last = last;
		return r;
	endfunction

	function automatic rx_result_t pay_res(logic [3:0] opc, logic fin, logic [7:0] data,
			logic last);
		rx_result_t r;
		r = '0;
		r.kind = KIND_PAYLOAD;
		r.opc = opc;
		r.fin = fin;
		r.data = data;
		r.last = last;
		return r;
	endfunction

	task automatic frame_parse(input logic [7:0] b, output bit has, output rx_result_t r);
		logic [6:0] code;
		logic [7:0] k;
		bit         bad;
		logic [1:0] ecode;
		has = 1'b0;
		r = '0;
		bad = 1'b0;
		ecode = ERR_NO_MASK;
		code = b[6:0];
		case (ph)
			PH_HDR1: begin
				cur_fin = b[7];
				cur_opc = b[3:0];
				ph = (b[6:4] != 3'b000) ? PH_HDR2_RSV : PH_HDR2;
			end
			PH_HDR2, PH_HDR2_RSV: begin
				if (!b[7]) begin
					bad = 1'b1;
					ecode = ERR_NO_MASK;
				end else if (ph == PH_HDR2_RSV) begin
					bad = 1'b1;
					ecode = ERR_RSV;
				end else if (cur_opc <= OPC_BINARY) begin
					bad = 1'b0;
				end else if (cur_opc >= OPC_CLOSE && cur_opc <= OPC_PONG) begin
					if (code > LEN_SINGLE_MAX || !cur_fin) begin
						bad = 1'b1;
						ecode = ERR_CONTROL;
					end
				end else begin
					bad = 1'b1;
					ecode = ERR_OPCODE;
				end
				if (bad) begin
					ph = PH_ERROR;
					has = 1'b1;
					r.kind = KIND_ERROR;
					r.opc = cur_opc;
					r.fin = cur_fin;
					r.err = ecode;
				end else begin
					len_accum = '0;
					if (code == LEN_EXT16) begin
						len_bytes_left = 4'd2;
						ph = PH_EXTLEN;
					end else if (code == LEN_EXT64) begin
						len_bytes_left = 4'd8;
						ph = PH_EXTLEN;
					end else begin
						len_accum = {57'd0, code};
						len_bytes_left = 4'd0;
						mask_bytes_left = 3'd4;
						mask_key = '0;
						ph = PH_MASK;
					end
				end
			end
			PH_EXTLEN: begin
				len_accum = {len_accum[55:0], b};
				len_bytes_left = len_bytes_left - 4'd1;
				if (len_bytes_left == 4'd0) begin
					mask_bytes_left = 3'd4;
					mask_key = '0;
					ph = PH_MASK;
				end
			end
			PH_MASK: begin
				mask_key = {mask_key[23:0], b};
				mask_bytes_left = mask_bytes_left - 3'd1;
				if (mask_bytes_left == 3'd0) begin
					payload_left = len_accum;
					mask_pos = 2'd0;
					has = 1'b1;
					r = hdr_res(cur_opc, cur_fin, len_accum, len_accum == 64'd0);
					ph = (len_accum == 64'd0) ? PH_HDR1 : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				// first mask byte received applies to payload byte 0
				k = mask_key[31 - 8 * mask_pos -: 8];
				mask_pos = mask_pos + 2'd1;
				payload_left = payload_left - 64'd1;
				has = 1'b1;
				r = pay_res(cur_opc, cur_fin, b ^ k, payload_left == 64'd0);
				if (payload_left == 64'd0)
					ph = PH_HDR1;
			end
			default: begin
				ph = PH_ERROR;
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input rx_result_t tres);
		bit         has;
		rx_result_t r;
		quiet = (bytes_sent >= 700 && bytes_sent < 1000);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
		frame_parse(b, has, r);
		if (typed)
			pending_results.push_back(tres);
		else if (has)
			pending_results.push_back(r);
	endtask

	task automatic send(input logic [7:0] b);
		send_byte(b, 1'b0, '0);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic row(input logic [7:0] b, input bit typed, input rx_result_t res);
		stim_row_t s;
		s.b = b;
		s.typed = typed;
		s.res = res;
		stim_table.push_back(s);
	endtask

	task automatic send_frame();
		logic [3:0]  opc;
		logic        fin;
		logic [63:0] len;
		logic [6:0]  code;
		logic [31:0] key;
		int          sel;
		sel = $urandom_range(0, 5);
		case (sel)
			0: opc = OPC_CONT;
			1: opc = OPC_TEXT;
			2: opc = OPC_BINARY;
			3: opc = OPC_CLOSE;
			4: opc = OPC_PING;
			default: opc = OPC_PONG;
		endcase
		fin = (opc >= OPC_CLOSE) ? 1'b1 : 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 9);
		if (opc >= OPC_CLOSE) begin
			len = ($urandom_range(0, 7) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
			code = len[6:0];
		end else if (sel <= 5) begin
			len = 64'($urandom_range(0, 24));
			code = len[6:0];
		end else if (sel == 6) begin
			len = 64'($urandom_range(100, 125));
			code = len[6:0];
		end else if (sel <= 8) begin
			len = 64'($urandom_range(0, 250));
			code = LEN_EXT16;
		end else begin
			len = 64'($urandom_range(0, 250));
			code = LEN_EXT64;
		end
		send({fin, 3'b000, opc});
		send({1'b1, code});
		if (code == LEN_EXT16) begin
			send(len[15:8]);
			send(len[7:0]);
		end else if (code == LEN_EXT64) begin
			for (int i = 7; i >= 0; i--)
				send(len[8 * i +: 8]);
		end
		key = $urandom;
		for (int i = 3; i >= 0; i--)
			send(key[8 * i +: 8]);
		for (longint j = 0; j < longint'(len); j++)
			send(8'($urandom));
	endtask

	// the parser never leaves the error phase, so the run closes with one bad header
	// or one frame too long to ever finish
	task automatic send_ending();
		int          sel;
		logic [3:0]  opc;
		logic [63:0] len;
		sel = $urandom_range(0, 4);
		case (sel)
			0: begin
				send({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 2))});
				send({1'b0, 7'($urandom)});
			end
			1: begin
				send({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), 4'($urandom)});
				send({1'b1, 7'($urandom)});
			end
			2: begin
				opc = 4'($urandom_range(OPC_CLOSE, OPC_PONG));
				if ($urandom_range(0, 1)) begin
					send({1'b0, 3'b000, opc});
					send({1'b1, 7'($urandom)});
				end else begin
					send({1'b1, 3'b000, opc});
					send({1'b1, $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64});
				end
			end
			3: begin
				opc = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
				send({1'($urandom_range(0, 1)), 3'b000, opc});
				send({1'b1, 7'($urandom)});
			end
			default: begin
				len = {32'($urandom), 32'($urandom)};
				len[63] = 1'($urandom_range(0, 1));
				len[62] = 1'b1;
				if ($urandom_range(0, 3) == 0)
					len = '1;
				send({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 2))});
				send({1'b1, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					send(len[8 * i +: 8]);
			end
		endcase
		// either ignored bytes after the error or payload of the endless frame
		for (int i = 0; i < 24; i++)
			send(8'($urandom));
	endtask

	always @(posedge clk) begin
		rx_result_t got;
		rx_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.opc = m_tdata[3:0];
			got.fin = m_tdata[4];
			got.len = m_tdata[68:5];
			got.data = m_tdata[76:69];
			got.last = m_tlast;
			got.err = m_tdata[78:77];
			if (pending_results.size() == 0) begin
				fails++;
				$display({"%0t: unexpected transaction kind=%0d opc=%0h fin=%0d len=%0h",
					" data=%0h last=%0d err=%0d"},
					$time, got.kind, got.opc, got.fin, got.len, got.data, got.last, got.err);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.opc !== want.opc || got.fin !== want.fin
						|| got.len !== want.len || got.data !== want.data
						|| got.last !== want.last || got.err !== want.err) begin
					fails++;
					$display({"%0t: expected kind=%0d opc=%0h fin=%0d len=%0h",
						" data=%0h last=%0d err=%0d"},
						$time, want.kind, want.opc, want.fin, want.len, want.data, want.last,
						want.err);
					$display({"%0t: actual   kind=%0d opc=%0h fin=%0d len=%0h",
						" data=%0h last=%0d err=%0d"},
						$time, got.kind, got.opc, got.fin, got.len, got.data, got.last,
						got.err);
				end
			end
		end
		if (quiet)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(0, 99) >= 9);
	end

	initial begin
		// empty final text frame, all-zero mask
		row(8'h81, 1'b0, '0);
		row(8'h80, 1'b0, '0);
		row(8'h00, 1'b0, '0);
		row(8'h00, 1'b0, '0);
		row(8'h00, 1'b0, '0);
		row(8'h00, 1'b1, hdr_res(OPC_TEXT, 1'b1, 64'd0, 1'b1));
		// non-final binary frame of two bytes, mask key rotates from its first byte
		row(8'h02, 1'b0, '0);
		row(8'h82, 1'b0, '0);
		row(8'hff, 1'b0, '0);
		row(8'h00, 1'b0, '0);
		row(8'ha5, 1'b0, '0);
		row(8'h5a, 1'b1, hdr_res(OPC_BINARY, 1'b0, 64'd2, 1'b0));
		row(8'h00, 1'b1, pay_res(OPC_BINARY, 1'b0, 8'hff, 1'b0));
		row(8'hff, 1'b1, pay_res(OPC_BINARY, 1'b0, 8'hff, 1'b1));
		// continuation with a 16-bit extended length of zero
		row(8'h80, 1'b0, '0);
		row(8'hfe, 1'b0, '0);
		row(8'h00, 1'b0, '0);
		row(8'h00, 1'b0, '0);
		row(8'h12, 1'b0, '0);
		row(8'h34, 1'b0, '0);
		row(8'h56, 1'b0, '0);
		row(8'h78, 1'b1, hdr_res(OPC_CONT, 1'b1, 64'd0, 1'b1));
		// one-byte pong, all-ones mask
		row(8'h8a, 1'b0, '0);
		row(8'h81, 1'b0, '0);
		row(8'hff, 1'b0, '0);
		row(8'hff, 1'b0, '0);
		row(8'hff, 1'b0, '0);
		row(8'hff, 1'b1, hdr_res(OPC_PONG, 1'b1, 64'd1, 1'b0));
		row(8'h5a, 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_byte(stim_table[i].b, stim_table[i].typed, stim_table[i].res);
		drain_results();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			send_frame();
			if (bytes_sent >= 400 && bytes_sent < 460)
				drain_results();
		end
		send_ending();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
